// ----- hdl/sbpcm_pkg.sv -----
// Package: shared types, result codes and the gain table of the stereo PCM decoder.
`default_nettype none
package sbpcm_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_CODE   = 2'd1,
        PH_SAMPLE = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_SHORT    = 2'd2
    } kind_t;

    localparam int GAIN_W = 15;
    localparam int PROD_W = 24;

    // one queued piece of work: a sample, a status, or a sample followed by a status
    typedef struct packed {
        logic              has_sample;
        logic              has_status;
        kind_t             status;
        logic [7:0]        sample_byte;
        logic [GAIN_W-1:0] gain;
        logic              right;
    } op_t;

    function automatic logic [GAIN_W-1:0] gain_of(input logic [3:0] idx);
        logic [GAIN_W-1:0] g;
        begin
            g = '0;
            case (idx)
                4'd0:    g = 15'd16512;
                4'd1:    g = 15'd8256;
                4'd2:    g = 15'd4128;
                4'd3:    g = 15'd2064;
                4'd4:    g = 15'd1032;
                4'd5:    g = 15'd516;
                4'd6:    g = 15'd258;
                4'd7:    g = 15'd192;
                4'd8:    g = 15'd129;
                4'd9:    g = 15'd88;
                4'd10:   g = 15'd64;
                4'd11:   g = 15'd56;
                4'd12:   g = 15'd48;
                4'd13:   g = 15'd40;
                4'd14:   g = 15'd36;
                default: g = 15'd32;
            endcase
            return g;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sbpcm_in_if.sv -----
// Interface: packet byte channel.
`default_nettype none
interface sbpcm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       packet_end;

    modport source (output valid, output packet_byte, output packet_end, input ready);
    modport sink   (input valid, input packet_byte, input packet_end, output ready);
endinterface
`default_nettype wire

// ----- hdl/sbpcm_out_if.sv -----
// Interface: decoded result channel.
`default_nettype none
interface sbpcm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [15:0] pcm_sample;
    logic               channel_right;
    logic               last_of_run;

    modport source (output valid, output result_kind, output pcm_sample,
                    output channel_right, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input pcm_sample,
                    input channel_right, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hdl/sbpcm_front.sv -----
// Front end: packet parser that turns each sample byte, and each packet end, into a queued operation.
`default_nettype none
module sbpcm_front
    import sbpcm_pkg::*;
#(
    parameter int PAIRS_PER_BLOCK = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sbpcm_in_if.sink    in_ch,
    input  wire logic   q_full,
    output logic        q_push,
    output op_t         q_op
);

    localparam int IDX_W = (2 * PAIRS_PER_BLOCK > 1) ? $clog2(2 * PAIRS_PER_BLOCK) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(2 * PAIRS_PER_BLOCK - 1);

    phase_t           phase_reg, phase_next, phase_adv;
    logic [7:0]       blocks_reg, blocks_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       lgain_reg, lgain_next;
    logic [3:0]       rgain_reg, rgain_next;
    logic             accept;
    logic [7:0]       code;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign code        = {in_ch.packet_byte[0], in_ch.packet_byte[7:1]};

    // next state
    always_comb
    begin
        phase_adv   = phase_reg;
        blocks_next = blocks_reg;
        idx_next    = idx_reg;
        lgain_next  = lgain_reg;
        rgain_next  = rgain_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    blocks_next = in_ch.packet_byte;
                    idx_next    = '0;
                    phase_adv   = (in_ch.packet_byte == 8'd0) ? PH_DONE : PH_CODE;
                end
                PH_CODE:
                begin
                    lgain_next = code[3:0];
                    rgain_next = code[7:4];
                    idx_next   = '0;
                    phase_adv  = PH_SAMPLE;
                end
                PH_SAMPLE:
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_next    = '0;
                        blocks_next = blocks_reg - 8'd1;
                        phase_adv   = (blocks_reg == 8'd1) ? PH_DONE : PH_CODE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                PH_DONE:
                begin
                    phase_adv = PH_DONE;
                end
                default:
                begin
                    phase_adv = PH_HEADER;
                end
            endcase
        end
        phase_next = phase_adv;
        if (accept && in_ch.packet_end)
        begin
            phase_next  = PH_HEADER;
            blocks_next = '0;
            idx_next    = '0;
            lgain_next  = '0;
            rgain_next  = '0;
        end
    end

    // outputs
    always_comb
    begin
        q_op.has_sample  = (phase_reg == PH_SAMPLE);
        q_op.has_status  = in_ch.packet_end;
        q_op.status      = (phase_adv == PH_DONE) ? KIND_COMPLETE : KIND_SHORT;
        q_op.sample_byte = in_ch.packet_byte;
        q_op.right       = idx_reg[0];
        q_op.gain        = gain_of(idx_reg[0] ? rgain_reg : lgain_reg);
        q_push           = accept && ((phase_reg == PH_SAMPLE) || in_ch.packet_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            blocks_reg <= '0;
            idx_reg    <= '0;
            lgain_reg  <= '0;
            rgain_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            blocks_reg <= blocks_next;
            idx_reg    <= idx_next;
            lgain_reg  <= lgain_next;
            rgain_reg  <= rgain_next;
        end
    end

    a_blocks_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CODE || phase_reg == PH_SAMPLE) |-> (blocks_reg != 8'd0))
        else $error("block count ran out while mid-packet");

endmodule
`default_nettype wire

// ----- hdl/sbpcm_fifo.sv -----
// Short operation queue between parser and arithmetic back end.
`default_nettype none
module sbpcm_fifo
    import sbpcm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    input  wire logic pop,
    output op_t       head_op,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_MAX);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full && push && !pop |=> full && (cnt_reg == CNT_MAX))
        else $error("queue fill count went past its depth");

endmodule
`default_nettype wire

// ----- hdl/sbpcm_back.sv -----
// Back end: gain multiply, floor shift, saturation and result sequencing.
`default_nettype none
module sbpcm_back
    import sbpcm_pkg::*;
#(
    parameter int PRODUCT_SHIFT = 5
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire op_t    head_op,
    input  wire logic   q_empty,
    output logic        q_pop,
    sbpcm_out_if.source out_ch
);

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

    // multiply stage
    logic                     s1_valid_reg;
    op_t                      s1_op_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;

    // output stage
    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic signed [15:0] out_pcm_reg, out_pcm_next;
    logic               out_right_reg, out_right_next;
    logic               out_last_reg, out_last_next;
    logic               pend_reg, pend_next;
    kind_t              pend_kind_reg, pend_kind_next;

    logic                     out_free, s1_take, s1_load;
    logic signed [15:0]       gain_s;
    logic signed [7:0]        byte_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    logic signed [15:0]       sat;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_take  = out_free && !pend_reg && s1_valid_reg;
    assign s1_load  = !s1_valid_reg || s1_take;
    assign q_pop    = s1_load && !q_empty;

    assign gain_s = signed'({1'b0, head_op.gain});
    assign byte_s = signed'(head_op.sample_byte);
    assign prod   = PROD_W'(gain_s) * PROD_W'(byte_s);

    assign shifted = s1_prod_reg >>> PRODUCT_SHIFT;
    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sat = 16'sd32767;
        end
        else if (shifted < SAT_LO)
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = shifted[15:0];
        end
    end

    // a sample with end of packet leaves its status pending until the sample has left the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_pcm_next   = out_pcm_reg;
        out_right_next = out_right_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        if (out_free)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_pcm_next   = '0;
                out_right_next = 1'b0;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end
            else if (s1_valid_reg)
            begin
                out_valid_next = 1'b1;
                if (s1_op_reg.has_sample)
                begin
                    out_kind_next  = KIND_SAMPLE;
                    out_pcm_next   = sat;
                    out_right_next = s1_op_reg.right;
                    out_last_next  = !s1_op_reg.has_status;
                    pend_next      = s1_op_reg.has_status;
                    pend_kind_next = s1_op_reg.status;
                end
                else
                begin
                    out_kind_next  = s1_op_reg.status;
                    out_pcm_next   = '0;
                    out_right_next = 1'b0;
                    out_last_next  = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= !q_empty;
            end
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_op_reg   <= head_op;
            s1_prod_reg <= prod;
        end
        out_kind_reg  <= out_kind_next;
        out_pcm_reg   <= out_pcm_next;
        out_right_reg <= out_right_next;
        out_last_reg  <= out_last_next;
        pend_kind_reg <= pend_kind_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_kind   = out_kind_reg;
    assign out_ch.pcm_sample    = out_pcm_reg;
    assign out_ch.channel_right = out_right_reg;
    assign out_ch.last_of_run   = out_last_reg;

    a_pend_behind_sample: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg && (out_kind_reg == KIND_SAMPLE) && !out_last_reg)
        else $error("pending status without a sample ahead of it");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg != KIND_SAMPLE)
        |-> out_last_reg && (out_pcm_reg == 16'sd0) && !out_right_reg)
        else $error("status result carries sample fields");

    a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_ch.ready |=> out_valid_reg && (out_kind_reg != KIND_SAMPLE))
        else $error("pending status not issued after its sample");

endmodule
`default_nettype wire

// ----- hdl/stereo_block_scaled_pcm_decoder.sv -----
// Top level: stereo block-scaled PCM decoder (parser, queue, arithmetic back end).
//
//  channel  dir  payload                                              handshake
//  in_ch    in   packet_byte[7:0], packet_end                         valid/ready
//  out_ch   out  result_kind[1:0], pcm_sample[15:0], channel_right,   valid/ready
//                last_of_run
//
// One byte is taken per cycle while the queue has room; a result passes through the queue
// entry, the multiply register and the output register before it is presented. A sample
// byte carrying packet end gives two results: the sample, then its status, which waits in
// a pending register until the sample leaves the output register.
// Reset clears parser state, queue, multiply valid, pending status and output valid.
// A stall on out_ch fills the queue, after which in_ch.ready drops.
`default_nettype none
module stereo_block_scaled_pcm_decoder
    import sbpcm_pkg::*;
#(
    parameter int PAIRS_PER_BLOCK = 32,
    parameter int PRODUCT_SHIFT   = 5,
    parameter int QUEUE_DEPTH     = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sbpcm_in_if.sink    in_ch,
    sbpcm_out_if.source out_ch
);

    op_t  push_op;
    op_t  head_op;
    logic q_push, q_pop, q_full, q_empty;

    sbpcm_front #(
        .PAIRS_PER_BLOCK(PAIRS_PER_BLOCK)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (push_op)
    );

    sbpcm_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    sbpcm_back #(
        .PRODUCT_SHIFT(PRODUCT_SHIFT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head_op (head_op),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire

// ----- tb/sv/stereo_block_scaled_pcm_decoder_tb.sv -----
// Testbench: random and directed packets through the stereo PCM decoder, checked against a predictor.
module stereo_block_scaled_pcm_decoder_tb;
    import sbpcm_pkg::*;

    localparam int PAIRS       = 32;
    localparam int SHIFT       = 5;
    localparam int BLOCK_BYTES = 2 * PAIRS + 1;
    localparam int TARGET_REQS = 450;
    localparam int CALM_TAIL   = 60;
    localparam int LONG_HOLD   = 100;
    localparam int LIMIT       = 200000;

    localparam int GAIN_LUT [16] = '{16512, 8256, 4128, 2064, 1032, 516, 258, 192,
                                     129, 88, 64, 56, 48, 40, 36, 32};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;    // hold off until every expected result is back
    } pkt_req_t;

    typedef struct {
        kind_t              kind;
        logic signed [15:0] pcm;
        logic               right;
        logic               last;
    } pcm_result_t;

    logic clk;
    logic rst_n;

    sbpcm_in_if  in_ch ();
    sbpcm_out_if out_ch ();

    stereo_block_scaled_pcm_decoder #(
        .PAIRS_PER_BLOCK (PAIRS),
        .PRODUCT_SHIFT   (SHIFT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pkt_req_t    pkt_q [$];
    pcm_result_t pcm_q [$];

    // decoder state as the predictor sees it
    phase_t      parse_phase;
    logic [7:0]  blocks_left;
    int unsigned byte_idx;
    logic [3:0]  gain_l;
    logic [3:0]  gain_r;

    int          error_count;
    int          checked_count;
    int unsigned cycle_count;
    logic        idling_on;
    logic        calm_tail;
    int          send_gap;
    int          recv_hold;
    logic        long_hold_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [15:0] scaled_pcm(input logic [7:0] b, input logic [3:0] gi);
        int prod;
        int q;
        prod = int'($signed(b)) * GAIN_LUT[gi];
        q = prod >>> SHIFT;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    task automatic clear_parser();
        parse_phase = PH_HEADER;
        blocks_left = '0;
        byte_idx    = 0;
        gain_l      = '0;
        gain_r      = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic e);
        pcm_result_t r;
        logic [7:0]  code;
        case (parse_phase)
            PH_HEADER:
            begin
                blocks_left = b;
                byte_idx    = 0;
                parse_phase = (b == 8'd0) ? PH_DONE : PH_CODE;
            end
            PH_CODE:
            begin
                code        = {b[0], b[7:1]};
                gain_l      = code[3:0];
                gain_r      = code[7:4];
                byte_idx    = 0;
                parse_phase = PH_SAMPLE;
            end
            PH_SAMPLE:
            begin
                r.kind  = KIND_SAMPLE;
                r.right = byte_idx[0];
                r.pcm   = scaled_pcm(b, r.right ? gain_r : gain_l);
                r.last  = !e;
                pcm_q.push_back(r);
                byte_idx++;
                if (byte_idx >= 2 * PAIRS)
                begin
                    byte_idx    = 0;
                    blocks_left = blocks_left - 8'd1;
                    parse_phase = (blocks_left == 8'd0) ? PH_DONE : PH_CODE;
                end
            end
            default:
            begin
            end
        endcase
        if (e)
        begin
            r.kind  = (parse_phase == PH_DONE) ? KIND_COMPLETE : KIND_SHORT;
            r.pcm   = '0;
            r.right = 1'b0;
            r.last  = 1'b1;
            pcm_q.push_back(r);
            clear_parser();
        end
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'hFF;
            3:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_req(input logic [7:0] b, input logic e, input logic d = 1'b0);
        pkt_req_t p;
        p.data  = b;
        p.last  = e;
        p.drain = d;
        pkt_q.push_back(p);
    endtask

    // half well-formed packets, the rest mostly cut short, a few of pure noise
    task automatic queue_packet();
        int unsigned sel;
        int unsigned body_len;
        int unsigned trail;
        logic [7:0]  hdr;
        logic        drain;
        logic        noise;
        logic [7:0]  body [$];
        drain = ($urandom_range(0, 7) == 0);
        sel   = $urandom_range(0, 19);
        noise = 1'b0;
        trail = 0;
        if (sel < 10)
        begin
            hdr      = (sel == 0) ? 8'd0 : ((sel < 8) ? 8'd1 : 8'd2);
            body_len = hdr * BLOCK_BYTES;
            trail    = $urandom_range(0, 3);
        end
        else if (sel < 17)
        begin
            hdr      = 8'($urandom_range(1, 255));
            body_len = $urandom_range(0, 2 * BLOCK_BYTES);
        end
        else
        begin
            hdr      = 8'($urandom_range(0, 255));
            body_len = $urandom_range(0, 8);
            noise    = 1'b1;
        end
        for (int i = 0; i < body_len; i++)
        begin
            if (noise || (i % BLOCK_BYTES) == 0)
                body.push_back(8'($urandom_range(0, 255)));
            else
                body.push_back(rand_sample());
        end
        for (int i = 0; i < trail; i++)
            body.push_back(8'($urandom_range(0, 255)));
        push_req(hdr, body.size() == 0, drain);
        for (int i = 0; i < body.size(); i++)
            push_req(body[i], (i == body.size() - 1) ||
                     (noise && $urandom_range(0, 3) == 0));
    endtask

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        clear_parser();

        // zero block count, with and without a trailing byte
        push_req(8'd0, 1'b1);
        push_req(8'd0, 1'b0);
        push_req(8'hAA, 1'b1);
        // end on the header and on the code byte
        push_req(8'd5, 1'b1);
        push_req(8'd1, 1'b0);
        push_req(8'h3C, 1'b1);
        // largest gain: both saturations, then end on a sample
        push_req(8'd1, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h7F, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(8'h01, 1'b1);
        // largest count, smallest gain, after the pipe has drained
        push_req(8'hFF, 1'b0, 1'b1);
        push_req(8'hFF, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h7F, 1'b0);
        push_req(8'h81, 1'b1);
        // split gains: left index 0, right index 8
        push_req(8'd1, 1'b0);
        push_req(8'h01, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h80, 1'b1);

        while (pkt_q.size() < TARGET_REQS)
            queue_packet();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pkt_q.size() != 0 || pcm_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (pcm_q.size() != 0)
        begin
            $error("%0d expected results never arrived", pcm_q.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // cycle limit and switching of the idling pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count <= 0;
            idling_on   <= 1'b1;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 300 == 299)
                idling_on <= ($urandom_range(0, 3) != 0);
            if (cycle_count > LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.packet_byte <= '0;
            in_ch.packet_end  <= 1'b0;
            send_gap          <= 0;
            calm_tail         <= 1'b0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_byte(in_ch.packet_byte, in_ch.packet_end);
                void'(pkt_q.pop_front());
            end
            if (pkt_q.size() < CALM_TAIL)
                calm_tail <= 1'b1;
            if (send_gap > 0)
            begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pkt_q.size() == 0 || (pkt_q[0].drain && pcm_q.size() != 0))
                in_ch.valid <= 1'b0;
            else if (!calm_tail && idling_on && $urandom_range(0, 9) == 0)
            begin
                send_gap    <= $urandom_range(1, 17) - 1;
                in_ch.valid <= 1'b0;
            end
            else
            begin
                in_ch.valid       <= 1'b1;
                in_ch.packet_byte <= pkt_q[0].data;
                in_ch.packet_end  <= pkt_q[0].last;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        pcm_result_t want;
        if (!rst_n)
        begin
            out_ch.ready   <= 1'b0;
            recv_hold      <= 0;
            long_hold_done <= 1'b0;
            checked_count  <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                checked_count <= checked_count + 1;
                if (pcm_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d sample %0d", out_ch.result_kind,
                           out_ch.pcm_sample);
                    error_count++;
                end
                else
                begin
                    want = pcm_q.pop_front();
                    if (out_ch.result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind,
                               out_ch.result_kind);
                        error_count++;
                    end
                    if (out_ch.pcm_sample !== want.pcm)
                    begin
                        $error("pcm_sample: expected %0d, got %0d", want.pcm,
                               out_ch.pcm_sample);
                        error_count++;
                    end
                    if (out_ch.channel_right !== want.right)
                    begin
                        $error("channel_right: expected %0d, got %0d", want.right,
                               out_ch.channel_right);
                        error_count++;
                    end
                    if (out_ch.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last,
                               out_ch.last_of_run);
                        error_count++;
                    end
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold    <= recv_hold - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && checked_count >= 150)
            begin
                // long stall: the queue fills and the input side must back off
                long_hold_done <= 1'b1;
                recv_hold      <= LONG_HOLD - 1;
                out_ch.ready   <= 1'b0;
            end
            else if (!calm_tail && idling_on && $urandom_range(0, 9) == 0)
            begin
                recv_hold    <= $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

endmodule
